// ----- rtl/twg_pkg.sv -----
package twg_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_WAVEFORM = 3'd0;
  localparam logic [2:0] CFG_DUTY     = 3'd1;
  localparam logic [2:0] CFG_AMP      = 3'd2;
  localparam logic [2:0] CFG_OFFSET   = 3'd3;
  localparam logic [2:0] CFG_PERIOD   = 3'd4;

  // waveform select codes
  localparam logic [2:0] WAVE_OFF      = 3'd0;
  localparam logic [2:0] WAVE_SINE     = 3'd1;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
  localparam logic [2:0] WAVE_SQUARE   = 3'd3;
  localparam logic [2:0] WAVE_SAW_UP   = 3'd4;
  localparam logic [2:0] WAVE_SAW_DOWN = 3'd5;
  localparam logic [2:0] WAVE_DC       = 3'd6;
  localparam logic [2:0] WAVE_UNUSED   = 3'd7;

  // field widths
  localparam int WAVE_W   = 3;
  localparam int DUTY_W   = 7;
  localparam int AMP_W    = 13;
  localparam int OFFSET_W = 14;
  localparam int PERIOD_W = 16;
  localparam int CFG_W    = 16;
  localparam int DAC_W    = 12;
  localparam int SHAPE_W  = 17;

  // reset values
  localparam logic [WAVE_W-1:0]   WAVE_RST   = WAVE_SINE;
  localparam logic [AMP_W-1:0]    AMP_RST    = 13'd2048;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd839;

  localparam int DEFAULT_TABLE_LENGTH = 100;

  // shape scale: +1.0 in Q2.15 (17-bit signed)
  localparam int Q_ONE      = 32768;
  localparam int Q_SHIFT    = 15;
  localparam int DAC_MID    = 2048;
  localparam int DAC_MAX    = 4095;

  // sine rom: 100 steps a period, half period is 50, quarter is 25
  localparam int SINE_STEPS = 100;
  localparam int SINE_HALF  = 50;
  localparam int SINE_QTR   = 25;
  localparam int QUARTER_SINE [26] = '{
    0, 2058, 4107, 6140, 8149, 10126, 12063, 13952, 15786, 17558,
    19261, 20887, 22431, 23887, 25248, 26510, 27667, 28715, 29649, 30467,
    31164, 31739, 32188, 32510, 32703, 32768
  };

endpackage

// ----- rtl/table_waveform_generator.sv -----
// Table waveform generator: every input item is one timer tick (restart=0) or a restart
// (restart=1, clears the tick divider and the phase index, no result). Every
// period_minus_one+1 ticks one 12-bit saturated DAC code is produced for the current table
// index, which then advances modulo TABLE_LENGTH; waveform off (or code 7) keeps counting
// but gives no result. One item is taken per clock cycle unless output back-pressure stalls
// it; results pass four registered stages: divider and phase index, shape table read,
// multiply by amplitude, offset add and clamp into the output register. The user must
// write configuration via cfg_wr_en/cfg_index/cfg_data while idle; the block won't enforce.
module table_waveform_generator #(
  parameter int TABLE_LENGTH = twg_pkg::DEFAULT_TABLE_LENGTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [2:0]                 cfg_index,
  input  logic [twg_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_restart,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [twg_pkg::DAC_W-1:0]  out_dac_code,
  output logic                       out_cycle_start
);

  localparam int PW = $clog2(TABLE_LENGTH);
  localparam logic [PW-1:0] LAST_IDX = PW'(TABLE_LENGTH - 1);
  localparam logic [PW-1:0] HALF_IDX = PW'(TABLE_LENGTH / 2);
  localparam int CMP_W = (PW > twg_pkg::DUTY_W) ? PW : twg_pkg::DUTY_W;
  localparam int SUM_W = 17;

  // configuration registers
  logic [twg_pkg::WAVE_W-1:0]          wave_r;
  logic [twg_pkg::DUTY_W-1:0]          duty_r;
  logic [twg_pkg::AMP_W-1:0]           amp_r;
  logic signed [twg_pkg::OFFSET_W-1:0] offset_r;
  logic [twg_pkg::PERIOD_W-1:0]        period_r;

  // divider state
  logic [twg_pkg::PERIOD_W-1:0] tick_r, tick_nxt;
  logic [PW-1:0]                phase_r, phase_nxt;

  // pipeline stages
  logic                                s1_vld_r, s1_vld_nxt, s1_first_r, s1_first_nxt;
  logic [PW-1:0]                       s1_idx_r, s1_idx_nxt;
  logic                                s2_vld_r, s2_first_r;
  logic signed [twg_pkg::SHAPE_W-1:0]  s2_shape_r, shape_nxt;
  logic                                s3_vld_r, s3_first_r;
  logic signed [30:0]                  s3_prod_r;
  logic                                out_vld_r, out_first_r;
  logic [twg_pkg::DAC_W-1:0]           out_code_r, code_nxt;

  logic en_out, en3, en2, en1, accept;

  // shape tables, constant per entry
  logic signed [twg_pkg::SHAPE_W-1:0] ramp_tbl [TABLE_LENGTH];
  logic signed [twg_pkg::SHAPE_W-1:0] sine_tbl [TABLE_LENGTH];

  for (genvar g = 0; g < TABLE_LENGTH; g++) begin : g_tbl
    localparam int RAMP = (2 * 65536 * g + (TABLE_LENGTH - 1)) / (2 * (TABLE_LENGTH - 1))
                          - twg_pkg::Q_ONE;
    localparam int SN   = (g * twg_pkg::SINE_STEPS) / TABLE_LENGTH;
    localparam int SQ   = SN % twg_pkg::SINE_HALF;
    localparam int SQI  = (SQ <= twg_pkg::SINE_QTR) ? SQ : (twg_pkg::SINE_HALF - SQ);
    localparam int SA   = twg_pkg::QUARTER_SINE[SQI];
    localparam int SV   = (SN >= twg_pkg::SINE_HALF) ? -SA : SA;
    assign ramp_tbl[g] = twg_pkg::SHAPE_W'(RAMP);
    assign sine_tbl[g] = twg_pkg::SHAPE_W'(SV);
  end

  // stage enables, each stage moves when its successor has room
  assign en_out   = !out_vld_r || out_ready;
  assign en3      = !s3_vld_r || en_out;
  assign en2      = !s2_vld_r || en3;
  assign en1      = !s1_vld_r || en2;
  assign in_ready = en1;
  assign accept   = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r   <= twg_pkg::WAVE_RST;
      duty_r   <= '0;
      amp_r    <= twg_pkg::AMP_RST;
      offset_r <= '0;
      period_r <= twg_pkg::PERIOD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        twg_pkg::CFG_WAVEFORM: wave_r   <= cfg_data[twg_pkg::WAVE_W-1:0];
        twg_pkg::CFG_DUTY:     duty_r   <= cfg_data[twg_pkg::DUTY_W-1:0];
        twg_pkg::CFG_AMP:      amp_r    <= cfg_data[twg_pkg::AMP_W-1:0];
        twg_pkg::CFG_OFFSET:   offset_r <= $signed(cfg_data[twg_pkg::OFFSET_W-1:0]);
        twg_pkg::CFG_PERIOD:   period_r <= cfg_data[twg_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // tick divider and phase index
  always_comb begin
    tick_nxt     = tick_r;
    phase_nxt    = phase_r;
    s1_vld_nxt   = 1'b0;
    s1_idx_nxt   = phase_r;
    s1_first_nxt = (phase_r == '0);
    if (accept) begin
      if (in_restart) begin
        tick_nxt  = '0;
        phase_nxt = '0;
      end else if (tick_r < period_r) begin
        tick_nxt = tick_r + 1'b1;
      end else begin
        tick_nxt   = '0;
        phase_nxt  = (phase_r == LAST_IDX) ? '0 : phase_r + 1'b1;
        s1_vld_nxt = (wave_r != twg_pkg::WAVE_OFF) && (wave_r != twg_pkg::WAVE_UNUSED);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      phase_r  <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      tick_r  <= tick_nxt;
      phase_r <= phase_nxt;
      if (en1) begin
        s1_vld_r <= s1_vld_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_idx_r   <= s1_idx_nxt;
      s1_first_r <= s1_first_nxt;
    end
  end

  // shape lookup for the sample index
  logic [PW-1:0] tri_j, ramp_k;
  logic [PW:0]   tri_k2;

  always_comb begin
    tri_j  = (s1_idx_r < HALF_IDX) ? s1_idx_r : (LAST_IDX - s1_idx_r);
    tri_k2 = {tri_j, 1'b0};
    case (wave_r)
      twg_pkg::WAVE_TRIANGLE: ramp_k = tri_k2[PW-1:0];
      twg_pkg::WAVE_SAW_DOWN: ramp_k = LAST_IDX - s1_idx_r;
      default:                ramp_k = s1_idx_r;
    endcase
    case (wave_r)
      twg_pkg::WAVE_SINE:     shape_nxt = sine_tbl[s1_idx_r];
      twg_pkg::WAVE_TRIANGLE,
      twg_pkg::WAVE_SAW_UP,
      twg_pkg::WAVE_SAW_DOWN: shape_nxt = ramp_tbl[ramp_k];
      twg_pkg::WAVE_SQUARE: begin
        if (CMP_W'(s1_idx_r) < CMP_W'(duty_r)) begin
          shape_nxt = twg_pkg::SHAPE_W'(twg_pkg::Q_ONE);
        end else begin
          shape_nxt = twg_pkg::SHAPE_W'(-twg_pkg::Q_ONE);
        end
      end
      default:                shape_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en2) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_shape_r <= shape_nxt;
      s2_first_r <= s1_first_r;
    end
  end

  // scale by amplitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en3) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_prod_r  <= 31'(s2_shape_r * $signed({1'b0, amp_r}));
      s3_first_r <= s2_first_r;
    end
  end

  // floor divide by one unit, add offset and midscale, saturate
  logic signed [15:0]      scaled;
  logic signed [SUM_W-1:0] sum;

  always_comb begin
    scaled = s3_prod_r[30:twg_pkg::Q_SHIFT];
    sum    = SUM_W'(scaled) + SUM_W'(offset_r) + SUM_W'(twg_pkg::DAC_MID);
    if (sum < 0) begin
      code_nxt = '0;
    end else if (sum > SUM_W'(twg_pkg::DAC_MAX)) begin
      code_nxt = twg_pkg::DAC_W'(twg_pkg::DAC_MAX);
    end else begin
      code_nxt = sum[twg_pkg::DAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en_out) begin
      out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_code_r  <= code_nxt;
      out_first_r <= s3_first_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_dac_code    = out_code_r;
  assign out_cycle_start = out_first_r;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 6;
  localparam int TABLE_LEN      = twg_pkg::DEFAULT_TABLE_LENGTH;
  localparam int DRAIN_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int TOTAL_ITEMS    = 1250;
  localparam int PRESSURE_PHASE = 2;
  localparam int LIMIT_CYCLES   = 500000;
  localparam int MAX_REPORTS    = 20;
  localparam int ALL_REGS       = 5'b11111;

  // quarter wave of the sine table, q2.15
  localparam int SINE_QUARTER [26] = '{
    0, 2058, 4107, 6140, 8149, 10126, 12063, 13952, 15786, 17558,
    19261, 20887, 22431, 23887, 25248, 26510, 27667, 28715, 29649, 30467,
    31164, 31739, 32188, 32510, 32703, 32768
  };

  typedef struct packed {
    logic [twg_pkg::DAC_W-1:0] dac_code;
    logic                      cycle_start;
  } dac_sample_t;

  // tracks the divider and phase index, predicts every dac sample
  class dac_scoreboard;
    logic [twg_pkg::WAVE_W-1:0]          waveform;
    logic [twg_pkg::DUTY_W-1:0]          duty;
    logic [twg_pkg::AMP_W-1:0]           amplitude;
    logic signed [twg_pkg::OFFSET_W-1:0] offset;
    logic [twg_pkg::PERIOD_W-1:0]        period;
    int unsigned                         tick_count;
    int                                  phase;
    dac_sample_t                         expected_samples[$];
    int                                  items;
    int                                  restarts;
    int                                  samples;
    int                                  errors;

    function new();
      waveform   = twg_pkg::WAVE_SINE;
      duty       = '0;
      amplitude  = 13'd2048;
      offset     = '0;
      period     = 16'd839;
      tick_count = 0;
      phase      = 0;
      items      = 0;
      restarts   = 0;
      samples    = 0;
      errors     = 0;
    endfunction

    function void write_register(logic [2:0] idx, logic [twg_pkg::CFG_W-1:0] data);
      case (idx)
        twg_pkg::CFG_WAVEFORM: waveform  = data[twg_pkg::WAVE_W-1:0];
        twg_pkg::CFG_DUTY:     duty      = data[twg_pkg::DUTY_W-1:0];
        twg_pkg::CFG_AMP:      amplitude = data[twg_pkg::AMP_W-1:0];
        twg_pkg::CFG_OFFSET:   offset    = data[twg_pkg::OFFSET_W-1:0];
        twg_pkg::CFG_PERIOD:   period    = data[twg_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    // round(65536*k/(L-1)) - 1.0
    function int ramp(int k);
      return (131072 * k + (TABLE_LEN - 1)) / (2 * (TABLE_LEN - 1)) - twg_pkg::Q_ONE;
    endfunction

    function int sine_at(int i);
      int n;
      int q;
      int v;
      n = i * twg_pkg::SINE_STEPS / TABLE_LEN;
      if (n >= twg_pkg::SINE_STEPS) n = twg_pkg::SINE_STEPS - 1;
      q = n % twg_pkg::SINE_HALF;
      v = (q <= twg_pkg::SINE_QTR) ? SINE_QUARTER[q] : SINE_QUARTER[twg_pkg::SINE_HALF - q];
      return (n >= twg_pkg::SINE_HALF) ? -v : v;
    endfunction

    function int shape_at(int i);
      case (waveform)
        twg_pkg::WAVE_SINE:     return sine_at(i);
        twg_pkg::WAVE_TRIANGLE: return ramp(2 * ((i < TABLE_LEN / 2) ? i : TABLE_LEN - 1 - i));
        twg_pkg::WAVE_SQUARE:   return (i < int'(duty)) ? twg_pkg::Q_ONE : -twg_pkg::Q_ONE;
        twg_pkg::WAVE_SAW_UP:   return ramp(i);
        twg_pkg::WAVE_SAW_DOWN: return ramp(TABLE_LEN - 1 - i);
        default:                return 0;
      endcase
    endfunction

    // floor(shape*amp/1.0) + offset + midscale, saturated to 12 bits
    function logic [twg_pkg::DAC_W-1:0] code_from_shape(int s);
      longint p;
      longint q;
      p = longint'(s) * longint'(amplitude);
      if (p >= 0) q = p / twg_pkg::Q_ONE;
      else q = -((-p + twg_pkg::Q_ONE - 1) / twg_pkg::Q_ONE);
      q = q + longint'(offset) + 2048;
      if (q < 0) q = 0;
      if (q > 4095) q = 4095;
      return q[twg_pkg::DAC_W-1:0];
    endfunction

    function void note_item(logic restart);
      int idx;
      dac_sample_t sample;
      items++;
      if (restart) begin
        restarts++;
        tick_count = 0;
        phase = 0;
        return;
      end
      // divider still counting
      if (tick_count < period) begin
        tick_count++;
        return;
      end
      tick_count = 0;
      idx = phase;
      phase = (idx + 1 >= TABLE_LEN) ? 0 : idx + 1;
      // off and unused selector advance silently
      if (waveform == twg_pkg::WAVE_OFF || waveform == twg_pkg::WAVE_UNUSED) return;
      sample.dac_code = code_from_shape(shape_at(idx));
      sample.cycle_start = (idx == 0);
      expected_samples.push_back(sample);
    endfunction

    function void check_sample(logic [twg_pkg::DAC_W-1:0] dac_code, logic cycle_start);
      dac_sample_t want;
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected sample, expected none, got dac_code %0d cycle_start %0d",
                   $time, dac_code, cycle_start);
        return;
      end
      want = expected_samples.pop_front();
      samples++;
      if (dac_code !== want.dac_code) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: dac_code expected %0d got %0d", $time, want.dac_code, dac_code);
      end
      if (cycle_start !== want.cycle_start) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: cycle_start expected %0d got %0d", $time, want.cycle_start,
                   cycle_start);
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [2:0]                 cfg_index = '0;
  logic [twg_pkg::CFG_W-1:0]  cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_restart = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b1;
  logic [twg_pkg::DAC_W-1:0]  out_dac_code;
  logic                       out_cycle_start;

  dac_scoreboard sb;
  bit            sender_quiet = 1'b0;
  bit            receiver_quiet = 1'b0;
  bit            hold_req = 1'b0;
  bit            hold_ack = 1'b0;
  int            hold_left = 0;
  int            stall_left = 0;
  int            phase_count = 0;

  table_waveform_generator u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dac_code    (out_dac_code),
    .out_cycle_start (out_cycle_start)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // gap lengths: mostly none, some short, a few long
  function automatic int idle_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // handshake monitor feeding the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_restart);
      if (out_valid && out_ready) sb.check_sample(out_dac_code, out_cycle_start);
    end
  end

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!receiver_quiet && $urandom_range(0, 99) < 25)
        stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                  : $urandom_range(8, 40);
    end
  end

  task automatic send_item(input logic restart);
    int gap;
    in_valid <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = idle_gap(sender_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering items and let everything in flight come out
  task automatic settle();
    in_valid <= 1'b0;
    // wait for a clock edge so the monitor has noted the last accepted item
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int mask, input logic [2:0] wave, input int duty,
                           input int amp, input int off, input int per);
    int i;
    logic [twg_pkg::CFG_W-1:0] data;
    for (i = 0; i < 5; i++) begin
      if (mask[i]) begin
        case (i)
          twg_pkg::CFG_WAVEFORM: data = twg_pkg::CFG_W'(wave);
          twg_pkg::CFG_DUTY:     data = twg_pkg::CFG_W'(duty[twg_pkg::DUTY_W-1:0]);
          twg_pkg::CFG_AMP:      data = twg_pkg::CFG_W'(amp[twg_pkg::AMP_W-1:0]);
          twg_pkg::CFG_OFFSET:   data = twg_pkg::CFG_W'(off[twg_pkg::OFFSET_W-1:0]);
          default:               data = twg_pkg::CFG_W'(per[twg_pkg::PERIOD_W-1:0]);
        endcase
        cfg_wr_en <= 1'b1;
        cfg_index <= 3'(i);
        cfg_data <= data;
        @(posedge clk);
        sb.write_register(3'(i), data);
      end
    end
    cfg_wr_en <= 1'b0;
    phase_count++;
  endtask

  initial begin
    logic [2:0] wave;
    int duty;
    int amp;
    int off;
    int per;
    int n;
    int r;
    int rand_phase;

    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, only the divider shortened
    configure(1 << twg_pkg::CFG_PERIOD, twg_pkg::WAVE_SINE, 0, 0, 0, 0);
    repeat (4) send_item(1'b0);
    settle();
    // every entry high, top amplitude and offset: saturates high
    configure(ALL_REGS, twg_pkg::WAVE_SQUARE, 127, 8191, 8191, 0);
    repeat (2) send_item(1'b0);
    settle();
    // nothing high, offset at the bottom: saturates low
    configure(ALL_REGS, twg_pkg::WAVE_SQUARE, 0, 8191, -8192, 0);
    repeat (2) send_item(1'b0);
    settle();
    // off and unused selector keep counting without output
    configure(1 << twg_pkg::CFG_WAVEFORM, twg_pkg::WAVE_OFF, 0, 0, 0, 0);
    repeat (3) send_item(1'b0);
    settle();
    configure(1 << twg_pkg::CFG_WAVEFORM, twg_pkg::WAVE_UNUSED, 0, 0, 0, 0);
    repeat (2) send_item(1'b0);
    settle();
    // dc with zero amplitude
    configure(ALL_REGS, twg_pkg::WAVE_DC, 0, 0, 0, 0);
    send_item(1'b0);
    settle();
    // restart back to index zero, then triangle and both saws
    configure(ALL_REGS, twg_pkg::WAVE_TRIANGLE, 50, 4095, -100, 0);
    send_item(1'b1);
    send_item(1'b0);
    settle();
    configure(1 << twg_pkg::CFG_WAVEFORM, twg_pkg::WAVE_SAW_UP, 0, 0, 0, 0);
    repeat (2) send_item(1'b0);
    settle();
    configure(1 << twg_pkg::CFG_WAVEFORM, twg_pkg::WAVE_SAW_DOWN, 0, 0, 0, 0);
    repeat (2) send_item(1'b0);
    settle();
    // longest period, then shorten it below the running divider
    configure(ALL_REGS, twg_pkg::WAVE_SINE, 0, 1000, 0, 65535);
    repeat (3) send_item(1'b0);
    settle();
    configure(1 << twg_pkg::CFG_PERIOD, twg_pkg::WAVE_SINE, 0, 0, 0, 1);
    repeat (2) send_item(1'b0);
    settle();

    // random settings, mostly short periods so samples come often
    rand_phase = 0;
    while (sb.items < TOTAL_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r == 0) wave = twg_pkg::WAVE_OFF;
      else if (r == 1) wave = twg_pkg::WAVE_UNUSED;
      else wave = 3'($urandom_range(1, 6));
      duty = $urandom_range(0, 127);
      r = $urandom_range(0, 9);
      if (r == 0) amp = 0;
      else if (r == 1) amp = 8191;
      else amp = $urandom_range(0, 8191);
      if ($urandom_range(0, 99) < 30) off = int'($urandom_range(0, 16383)) - 8192;
      else off = int'($urandom_range(0, 1600)) - 800;
      r = $urandom_range(0, 99);
      if (r < 55) per = 0;
      else if (r < 80) per = $urandom_range(1, 3);
      else if (r < 95) per = $urandom_range(4, 40);
      else per = $urandom_range(0, 65535);
      n = $urandom_range(20, 80);
      sender_quiet = ($urandom_range(0, 4) == 0);
      receiver_quiet = ($urandom_range(0, 4) == 0);
      // back-pressure phase: full rate in, output held off
      if (rand_phase == PRESSURE_PHASE) begin
        wave = twg_pkg::WAVE_SINE;
        per = 0;
        n = 150;
        sender_quiet = 1'b1;
      end
      configure(ALL_REGS, wave, duty, amp, off, per);
      if (rand_phase == PRESSURE_PHASE) hold_req = !hold_req;
      repeat (n) send_item($urandom_range(0, 99) < 3);
      settle();
      rand_phase++;
    end

    $display("run covered %0d items (%0d restarts) over %0d register settings",
             sb.items, sb.restarts, phase_count);
    $display("%0d dac samples compared, %0d mismatches", sb.samples, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS table_waveform_generator");
    end else begin
      $display("FAIL table_waveform_generator");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("timed out with %0d samples outstanding", sb.pending());
    $display("FAIL table_waveform_generator");
    $finish;
  end

endmodule
